/* hdl/q16_16_saturating_alu_macros.svh */
// Assertion helpers for the Q16.16 ALU checker
`ifndef Q16_16_SATURATING_ALU_MACROS_SVH
`define Q16_16_SATURATING_ALU_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define QALU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define QALU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/qalu_pkg.sv */
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared types and constants of the Q16.16 saturating ALU.
// ----------------------------------------------------------------------------
package qalu_pkg;
    localparam int DATA_W = 32;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;
    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]  kind;
        logic        valid;
    } t_ctl;
endpackage

/* hdl/qalu_div.sv */
// ----------------------------------------------------------------------------
// qalu_div
// Pipelined restoring divider, one quotient bit per stage, magnitudes only.
// ----------------------------------------------------------------------------
module qalu_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);
    // remainder and divisor are only needed up to the last stage's input
    logic [DEN_W:0]   r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W+1];
    logic [DEN_W-1:0] r_den [NUM_W];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_num[0] <= i_num;
        r_den[0] <= i_den;
    end

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W+1:0] w_try;
        logic [DEN_W+1:0] w_sh;
        assign w_sh  = {r_rem[s], r_num[s][NUM_W-1]};
        assign w_try = w_sh - {2'b00, r_den[s]};
        always_ff @(posedge i_clk) begin
            r_num[s+1] <= {r_num[s][NUM_W-2:0], ~w_try[DEN_W+1]};
        end
        if (s < NUM_W - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (!w_try[DEN_W+1]) begin
                    r_rem[s+1] <= w_try[DEN_W:0];
                end else begin
                    r_rem[s+1] <= w_sh[DEN_W:0];
                end
                r_den[s+1] <= r_den[s];
            end
        end
    end

    assign o_quo = r_num[NUM_W];
endmodule

/* hdl/q16_16_saturating_alu.sv */
// ----------------------------------------------------------------------------
// q16_16_saturating_alu
// Signed fixed-point add, subtract, multiply and divide with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: i_start with i_kind, i_operand_a, i_operand_b. A
//   transaction is taken on each rising edge with i_start high and o_busy
//   low. o_busy is tied low: the pipeline takes one transaction per cycle.
//   Result channel: o_done pulses for one cycle with o_result_value,
//   o_clipped and o_zero_divisor. The receiver cannot stall; results come
//   out in command order.
//   Pipeline: every operation goes through the same stages, and the
//   divider sets their number: one quotient bit per stage (32+FRAC_BITS
//   stages), behind an input stage, a sign/magnitude stage and a divider
//   entry stage, then the saturation stage drives the outputs. Add,
//   subtract and multiply run through a delay line of the same depth so
//   all results keep order.
//   Multiply: 32x32 product registered, then round/shift/clamp next stage.
//   Reset (i_rst_n low, synchronous) clears all valid bits; no result is
//   produced for commands in flight at reset.
// ----------------------------------------------------------------------------
module q16_16_saturating_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [1:0]                        i_kind,
    input  logic signed [qalu_pkg::DATA_W-1:0] i_operand_a,
    input  logic signed [qalu_pkg::DATA_W-1:0] i_operand_b,
    output logic                              o_done,
    output logic signed [qalu_pkg::DATA_W-1:0] o_result_value,
    output logic                              o_clipped,
    output logic                              o_zero_divisor
);
    import qalu_pkg::*;

    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int DLY   = NUM_W + 1;  // divider entry + stages

    // Stage 1: capture
    t_ctl r_c1;
    logic signed [DATA_W-1:0] r_a1, r_b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.valid <= 1'b0;
        end else begin
            r_c1.valid <= i_start;
        end
        r_c1.kind <= i_kind;
        r_a1 <= i_operand_a;
        r_b1 <= i_operand_b;
    end

    // Stage 2: add/sub exact, product, divider magnitudes
    t_ctl r_c2;
    logic signed [DATA_W:0]     r_sum2;
    logic signed [2*DATA_W-1:0] r_prod2;
    logic [NUM_W-1:0]           r_num2;
    logic [DATA_W-1:0]          r_den2;
    logic                       r_neg2, r_zdiv2, r_aneg2;
    logic [DATA_W:0]            w_amag;
    assign w_amag = r_a1[DATA_W-1] ? (DATA_W+1)'(-$signed({r_a1[DATA_W-1], r_a1}))
                                   : (DATA_W+1)'($signed({r_a1[DATA_W-1], r_a1}));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2.valid <= 1'b0;
        end else begin
            r_c2.valid <= r_c1.valid;
        end
        r_c2.kind <= r_c1.kind;
        if (r_c1.kind == OP_SUB) begin
            r_sum2 <= {r_a1[DATA_W-1], r_a1} - {r_b1[DATA_W-1], r_b1};
        end else begin
            r_sum2 <= {r_a1[DATA_W-1], r_a1} + {r_b1[DATA_W-1], r_b1};
        end
        r_prod2 <= r_a1 * r_b1;
        r_num2  <= NUM_W'({w_amag, {FRAC_BITS{1'b0}}});
        r_den2  <= r_b1[DATA_W-1] ? DATA_W'(-r_b1) : DATA_W'(r_b1);
        r_neg2  <= r_a1[DATA_W-1] ^ r_b1[DATA_W-1];
        r_zdiv2 <= (r_b1 == '0);
        r_aneg2 <= r_a1[DATA_W-1];
    end

    // Stage 3: non-divide result computed, then delayed
    logic signed [DATA_W-1:0] w_res3;
    logic                     w_clip3;
    logic signed [2*DATA_W-1:0] w_rnd;
    logic signed [2*DATA_W-FRAC_BITS-1:0] w_sh;
    assign w_rnd = r_prod2 + (2*DATA_W)'(64'sd1 <<< (FRAC_BITS - 1));
    assign w_sh  = w_rnd[2*DATA_W-1:FRAC_BITS];
    always_comb begin
        w_res3  = r_sum2[DATA_W-1:0];
        w_clip3 = 1'b0;
        case (r_c2.kind)
            OP_ADD, OP_SUB: begin
                if (r_sum2[DATA_W] != r_sum2[DATA_W-1]) begin
                    w_clip3 = 1'b1;
                    w_res3  = r_sum2[DATA_W] ? SAT_MIN : SAT_MAX;
                end
            end
            OP_MUL: begin
                w_res3 = w_sh[DATA_W-1:0];
                if (w_sh > (2*DATA_W-FRAC_BITS)'(SAT_MAX)) begin
                    w_clip3 = 1'b1;
                    w_res3  = SAT_MAX;
                end else if (w_sh < (2*DATA_W-FRAC_BITS)'(SAT_MIN)) begin
                    w_clip3 = 1'b1;
                    w_res3  = SAT_MIN;
                end
            end
            default: begin
                w_res3  = '0;
                w_clip3 = 1'b0;
            end
        endcase
    end

    t_ctl                     r_cd   [DLY];
    logic signed [DATA_W-1:0] r_resd [DLY];
    logic                     r_clpd [DLY];
    logic [2:0]               r_sgd  [DLY];  // neg, zdiv, aneg
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DLY; i++) r_cd[i].valid <= 1'b0;
        end else begin
            r_cd[0].valid <= r_c2.valid;
            for (int i = 1; i < DLY; i++) r_cd[i].valid <= r_cd[i-1].valid;
        end
        r_cd[0].kind <= r_c2.kind;
        r_resd[0] <= w_res3;
        r_clpd[0] <= w_clip3;
        r_sgd[0]  <= {r_neg2, r_zdiv2, r_aneg2};
        for (int i = 1; i < DLY; i++) begin
            r_cd[i].kind <= r_cd[i-1].kind;
            r_resd[i] <= r_resd[i-1];
            r_clpd[i] <= r_clpd[i-1];
            r_sgd[i]  <= r_sgd[i-1];
        end
    end

    // Divider: NUM_W+1 register levels from r_num2 to quotient
    logic [NUM_W-1:0] w_quo;
    qalu_div #(.NUM_W(NUM_W), .DEN_W(DATA_W)) u_div (
        .i_clk (i_clk),
        .i_num (r_num2),
        .i_den (r_den2),
        .o_quo (w_quo)
    );

    // Final stage: quotient sign and clamp; aligned with r_cd[NUM_W]
    t_ctl                     w_cf;
    logic [2:0]               w_sg;
    logic signed [DATA_W-1:0] n_res;
    logic                     n_clip, n_zdiv;
    assign w_cf = r_cd[NUM_W];
    assign w_sg = r_sgd[NUM_W];
    always_comb begin
        n_res  = r_resd[NUM_W];
        n_clip = r_clpd[NUM_W];
        n_zdiv = 1'b0;
        if (w_cf.kind == OP_DIV) begin
            if (w_sg[1]) begin
                n_zdiv = 1'b1;
                n_clip = 1'b1;
                n_res  = w_sg[0] ? SAT_MIN : SAT_MAX;
            end else if (w_sg[2]) begin
                if (w_quo > NUM_W'(33'h8000_0000)) begin
                    n_clip = 1'b1;
                    n_res  = SAT_MIN;
                end else begin
                    n_clip = 1'b0;
                    n_res  = DATA_W'(-w_quo);
                end
            end else begin
                if (w_quo > NUM_W'(SAT_MAX)) begin
                    n_clip = 1'b1;
                    n_res  = SAT_MAX;
                end else begin
                    n_clip = 1'b0;
                    n_res  = DATA_W'(w_quo);
                end
            end
        end
    end

    logic r_done;
    logic signed [DATA_W-1:0] r_res;
    logic r_clip, r_zdiv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_cf.valid;
        end
        r_res  <= n_res;
        r_clip <= n_clip;
        r_zdiv <= n_zdiv;
    end

    assign o_busy         = 1'b0;
    assign o_done         = r_done;
    assign o_result_value = r_res;
    assign o_clipped      = r_clip;
    assign o_zero_divisor = r_zdiv;
endmodule

/* hdl/qalu_checker.sv */
// ----------------------------------------------------------------------------
// qalu_checker
// Port-level checks of the Q16.16 ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "q16_16_saturating_alu_macros.svh"
module qalu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_busy,
    input logic        o_done,
    input logic [31:0] o_result_value,
    input logic        o_clipped,
    input logic        o_zero_divisor
);
    `QALU_ASSERT_IMP(a_zdiv_clip, i_clk, i_rst_n, o_done && o_zero_divisor, o_clipped, "zero divisor without clip")
    `QALU_ASSERT_IMP(a_clip_ext, i_clk, i_rst_n, o_done && o_clipped && !o_zero_divisor, o_result_value == 32'h7fff_ffff || o_result_value == 32'h8000_0000, "clip not at range end")
    `QALU_ASSERT_IMP(a_never_busy, i_clk, i_rst_n, 1'b1, !o_busy, "busy raised")
    `QALU_ASSERT_NEXT(a_reset_quiet, i_clk, 1'b1, !i_rst_n, !o_done, "done right after reset")
endmodule

bind q16_16_saturating_alu qalu_checker u_qalu_checker (.*);
